FILE: src/serial_line_command_decoder_assert.svh
// ----------------------------------------------------------------------------
// serial line command decoder assertion macros
// concurrent checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_COMMAND_DECODER_ASSERT_SVH
`define SERIAL_LINE_COMMAND_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define SLCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slcd assertion failed");

// condition must never be seen out of reset
`define SLCD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("slcd forbidden condition seen");

`else

`define SLCD_ASSERT(lbl, clk, rst_n, prop)
`define SLCD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: src/slcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types, character codes and helpers of the serial line command decoder
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int LINE_CAPACITY_DEF = 32;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_C     = 8'd67;
    localparam logic [7:0] CH_S     = 8'd83;
    localparam logic [7:0] CH_V     = 8'd86;
    localparam logic [7:0] CH_X     = 8'd88;
    localparam logic [7:0] CH_Z     = 8'd90;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_SELECT_SERVO = 3'd1,
        ACT_SET_SERVO    = 3'd2,
        ACT_ROT_RIGHT    = 3'd3,
        ACT_ROT_LEFT     = 3'd4,
        ACT_FORWARD      = 3'd5,
        ACT_BACK         = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_num_phase;

    // per-byte control from the top level to the line trackers
    typedef struct packed {
        logic store;     // byte taken into the line
        logic pair_en;   // a previous byte exists in this line
        logic parse_en;  // third byte of the line or later
        logic clear;     // line ends or is discarded
    } t_step_ctl;

    typedef struct packed {
        logic        echo_valid;
        logic        echo_lf_first;
        logic [7:0]  echo_byte;
        logic        line_done;
        t_action     action;
        logic [31:0] servo_index;
        logic [31:0] number_value;
        logic        overflow_dropped;
    } t_result;

    function automatic logic [5:0] pair_bits(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] bits;
        bits    = '0;
        bits[0] = (a == CH_A) && (b == CH_A);
        bits[1] = (a == CH_A) && (b == CH_S);
        bits[2] = (a == CH_Z) && (b == CH_Z);
        bits[3] = (a == CH_X) && (b == CH_X);
        bits[4] = (a == CH_C) && (b == CH_C);
        bits[5] = (a == CH_V) && (b == CH_V);
        return bits;
    endfunction

    // lowest set bit wins
    function automatic t_action pick_action(input logic [5:0] pairs);
        t_action act;
        act = ACT_NONE;
        if (pairs[0])      act = ACT_SELECT_SERVO;
        else if (pairs[1]) act = ACT_SET_SERVO;
        else if (pairs[2]) act = ACT_ROT_RIGHT;
        else if (pairs[3]) act = ACT_ROT_LEFT;
        else if (pairs[4]) act = ACT_FORWARD;
        else if (pairs[5]) act = ACT_BACK;
        return act;
    endfunction

endpackage

FILE: src/slcd_num_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_num_parser
// incremental base-10 parser: whitespace, optional sign, saturating digits
// ----------------------------------------------------------------------------
module slcd_num_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slcd_pkg::t_step_ctl  i_ctl,
    input  logic [7:0]           i_byte,
    output logic [31:0]          o_value
);
    import slcd_pkg::*;

    t_num_phase  r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [31:0] r_mag, n_mag;

    logic        is_space;
    logic        is_digit;
    logic [35:0] acc;
    logic [31:0] acc_sat;

    assign is_space = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    // mag * 10 as two shifts, plus the digit
    assign acc = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
               + {28'b0, i_byte - CH_ZERO};
    assign acc_sat = (acc > {4'b0, MAG_CAP}) ? MAG_CAP : acc[31:0];

    // CR and LF never change the parse, so the registered value is final
    assign o_value = r_neg ? (32'd0 - r_mag) : ((r_mag >= MAG_CAP) ? POS_MAX : r_mag);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        if (i_ctl.clear) begin
            n_phase = PH_SKIP;
            n_neg   = 1'b0;
            n_mag   = '0;
        end else if (i_ctl.parse_en) begin
            case (r_phase)
                PH_SKIP: begin
                    if (is_space) begin
                        n_phase = PH_SKIP;
                    end else if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS)) begin
                        n_neg   = (i_byte == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (is_digit) begin
                        n_mag   = acc_sat;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_digit) begin
                        n_mag   = acc_sat;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
        end
    end

endmodule

FILE: src/slcd_pair_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pair_tracker
// remembers which two-letter commands appeared as adjacent bytes in the line
// ----------------------------------------------------------------------------
module slcd_pair_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slcd_pkg::t_step_ctl  i_ctl,
    input  logic [7:0]           i_byte,
    output slcd_pkg::t_action    o_action
);
    import slcd_pkg::*;

    logic [7:0] r_prev, n_prev;
    logic [5:0] r_pairs, n_pairs;
    logic [5:0] seen;

    assign seen     = r_pairs | (i_ctl.pair_en ? pair_bits(r_prev, i_byte) : 6'b0);
    assign o_action = pick_action(seen);

    always_comb begin
        n_prev  = r_prev;
        n_pairs = r_pairs;
        if (i_ctl.clear) begin
            n_prev  = '0;
            n_pairs = '0;
        end else if (i_ctl.store) begin
            n_prev  = i_byte;
            n_pairs = seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_pairs <= '0;
        end else begin
            r_prev  <= n_prev;
            r_pairs <= n_pairs;
        end
    end

endmodule

FILE: src/serial_line_command_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_command_decoder
// turns received serial bytes into echo bytes, line ends and command actions
// ----------------------------------------------------------------------------
// usage:
//   slave stream (i_s_*) takes one received byte per transaction; master
//   stream (o_m_*) gives exactly one result per accepted byte. tlast marks
//   the result of a byte that ended a line with CR or LF.
//   the echo enable register is written over i_cfg_valid / i_cfg_data and is
//   accepted every cycle; write it only while no result is pending.
// result path:
//   a result appears in the cycle after its byte is accepted and one byte can
//   be taken every cycle unless a held result stalls the input: the whole decode
//   runs between the input handshake and the single result register.
// reset:
//   synchronous, active low; the line state and the stored servo index clear,
//   echo is enabled, and the result register is emptied.
// stall:
//   while the result register is full and i_m_tready is low, o_s_tready is
//   low and the held result stays unchanged; a taken result frees the slot in
//   the same cycle, so a new byte can be accepted then.
// ----------------------------------------------------------------------------
module serial_line_command_decoder #(
    parameter int LINE_CAPACITY = slcd_pkg::LINE_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // echo_enable
    // received bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] rx_byte
    // decode results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,      // [7:0] echo_byte, [10:8] action,
                                        // [42:11] servo_index,
                                        // [74:43] number_value, rest zero
    output logic        o_m_tlast,      // line_done
    output logic [2:0]  o_m_tuser       // [0] echo_valid, [1] echo_lf_first,
                                        // [2] overflow_dropped
);
    import slcd_pkg::*;

    localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

    logic             r_echo_en;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_servo, n_servo;
    logic             r_out_valid;
    t_result          r_res, n_res;

    logic       s_acc;
    logic       full;
    logic       is_eol;
    t_step_ctl  ctl;
    t_action    action;
    logic [31:0] value;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_acc       = i_s_tvalid && o_s_tready;

    assign full   = r_count >= CNT_W'(LINE_CAPACITY);
    assign is_eol = (i_s_tdata == CH_CR) || (i_s_tdata == CH_LF);

    always_comb begin
        ctl.store    = s_acc && !full;
        ctl.pair_en  = s_acc && !full && (r_count != '0);
        ctl.parse_en = s_acc && !full && (r_count >= CNT_W'(2));
        ctl.clear    = s_acc && (full || is_eol);
    end

    slcd_pair_tracker u_pairs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_byte   (i_s_tdata),
        .o_action (action)
    );

    slcd_num_parser u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_byte  (i_s_tdata),
        .o_value (value)
    );

    always_comb begin
        n_res   = '0;
        n_count = r_count;
        n_servo = r_servo;
        if (full) begin
            n_res.overflow_dropped = 1'b1;
        end else begin
            n_res.echo_valid    = r_echo_en;
            n_res.echo_lf_first = r_echo_en && (i_s_tdata == CH_CR);
            n_res.echo_byte     = r_echo_en ? i_s_tdata : 8'd0;
            n_count             = r_count + CNT_W'(1);
            if (is_eol) begin
                n_res.line_done    = 1'b1;
                n_res.action       = action;
                n_res.number_value = value;
                n_res.servo_index  = (action == ACT_SET_SERVO) ? r_servo : 32'd0;
                if (action == ACT_SELECT_SERVO) begin
                    n_servo = value;
                end
            end
        end
        if (full || is_eol) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en   <= 1'b1;
            r_count     <= '0;
            r_servo     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_echo_en <= i_cfg_data;
            end
            if (s_acc) begin
                r_count <= n_count;
                r_servo <= n_servo;
            end
            if (o_s_tready) begin
                r_out_valid <= s_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_res.number_value, r_res.servo_index,
                         r_res.action, r_res.echo_byte};
    assign o_m_tlast  = r_res.line_done;
    assign o_m_tuser  = {r_res.overflow_dropped, r_res.echo_lf_first, r_res.echo_valid};

`include "serial_line_command_decoder_assert.svh"

    // line length stays within capacity
    `SLCD_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(LINE_CAPACITY))
    // a command action is only reported at a line end
    `SLCD_ASSERT(a_action_on_eol, i_clk, i_rst_n, (r_out_valid && (r_res.action != ACT_NONE)) |-> r_res.line_done)
    // a dropped byte gives no echo and ends no line
    `SLCD_ASSERT(a_drop_alone, i_clk, i_rst_n, (r_out_valid && r_res.overflow_dropped) |-> (!r_res.line_done && !r_res.echo_valid))
    // a line end or a drop restarts the line
    `SLCD_ASSERT(a_line_restart, i_clk, i_rst_n, (s_acc && (full || is_eol)) |=> (r_count == '0))

endmodule
